@@ src/mlpwm_pkg.sv @@
// Shared constants and types for the multichannel LED PWM with fade.
// No dependencies; imported by the top level.
package mlpwm_pkg;

	localparam int LED_COUNT = 8;
	localparam int PERIOD    = 256;

	localparam int PHASE_W   = $clog2(PERIOD);
	localparam int STEP_W    = 8;
	localparam int CH_W      = 3;
	localparam int FADE_W    = 10;
	localparam int REQ_W     = 3;
	localparam int PAT_W     = 8;
	localparam int PAT_N     = (LED_COUNT < PAT_W) ? LED_COUNT : PAT_W;
	localparam int SUM_W     = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam logic [FADE_W-1:0]  FADE_RESET = FADE_W'(50);
	localparam logic [PHASE_W-1:0] PHASE_TOP  = PHASE_W'(PERIOD - 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 3'd0,
		REQ_ADD   = 3'd1,
		REQ_LOCK  = 3'd2,
		REQ_STOP  = 3'd3,
		REQ_START = 3'd4
	} req_t;

	typedef logic [PHASE_W-1:0] cmp_t;

endpackage

@@ src/multichannel_led_pwm_with_fade.sv @@
// Top level of the multichannel LED PWM with fade: request register, state update, result register.
// Depends on mlpwm_pkg.
//
// All channels are compared and updated in parallel in one pass; each result is registered.
// Throughput: one request per cycle while the result register is empty or being taken.
// Backpressure: the request register advances whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous): stopped, phase and fade counters zero, compares zero,
// locks clear, LEDs off, fade_interval 50; no transaction pending on either side.
module multichannel_led_pwm_with_fade (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mlpwm_pkg::IN_DATA_W-1:0]       s_tdata,  // [2:0] channel, [10:3] brightness_step
	input  logic [mlpwm_pkg::REQ_W-1:0]           s_tuser,  // [2:0] req_type
	// result channel
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mlpwm_pkg::OUT_DATA_W-1:0]      m_tdata,  // [7:0] led_pattern, [8] is_running
	// fade_interval register write
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mlpwm_pkg::FADE_W-1:0]          cfg_data
);
	import mlpwm_pkg::*;

	// request stage
	logic                s1_valid_s1;
	logic [REQ_W-1:0]    req_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [STEP_W-1:0]   step_s1;
	logic                advance;

	// block state
	logic [FADE_W-1:0]   fade_interval_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [FADE_W-1:0]   fade_cnt_q;
	cmp_t                cmp_q   [LED_COUNT];
	logic [LED_COUNT-1:0] lock_q;
	logic [LED_COUNT-1:0] level_q;
	logic                running_q;

	// next state
	logic [PHASE_W-1:0]  phase_d;
	logic [FADE_W-1:0]   fade_cnt_d;
	cmp_t                cmp_d   [LED_COUNT];
	logic [LED_COUNT-1:0] lock_d;
	logic [LED_COUNT-1:0] level_d;
	logic                running_d;
	logic [PAT_W-1:0]    pattern_d;

	// tick helpers
	logic [PHASE_W-1:0]  phase_inc;
	logic [FADE_W-1:0]   interval;
	logic                fade_fire;
	logic [SUM_W-1:0]    sum [LED_COUNT];

	assign cfg_ready = 1'b1;
	assign advance   = s1_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser;
			ch_s1   <= s_tdata[CH_W-1:0];
			step_s1 <= s_tdata[CH_W+STEP_W-1:CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_interval_q <= FADE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fade_interval_q <= cfg_data;
		end
	end

	// zero interval behaves as one; fire once the counter reaches interval-1 or beyond
	assign interval  = (fade_interval_q == '0) ? FADE_W'(1) : fade_interval_q;
	assign fade_fire = ({1'b0, fade_cnt_q} + (FADE_W+1)'(1)) >= {1'b0, interval};
	assign phase_inc = (phase_q == PHASE_TOP) ? '0 : phase_q + PHASE_W'(1);

	always_comb begin
		phase_d    = phase_q;
		fade_cnt_d = fade_cnt_q;
		lock_d     = lock_q;
		level_d    = level_q;
		running_d  = running_q;
		for (int i = 0; i < LED_COUNT; i++) begin
			cmp_d[i] = cmp_q[i];
			sum[i]   = SUM_W'(cmp_q[i]) + SUM_W'(step_s1);
		end

		unique case (req_s1)
			REQ_TICK: begin
				if (running_q) begin
					phase_d = phase_inc;
					// levels use the compares from before this tick's fade step
					for (int i = 0; i < LED_COUNT; i++) begin
						if (phase_inc == cmp_q[i]) begin
							level_d[i] = 1'b0;
						end else if (phase_inc == '0) begin
							level_d[i] = 1'b1;
						end
					end
					if (fade_fire) begin
						fade_cnt_d = '0;
						for (int i = 0; i < LED_COUNT; i++) begin
							if (!lock_q[i] && cmp_q[i] != '0) begin
								cmp_d[i] = cmp_q[i] - PHASE_W'(1);
							end
						end
					end else begin
						fade_cnt_d = fade_cnt_q + FADE_W'(1);
					end
				end
			end
			REQ_ADD: begin
				// out-of-range channels match no lane
				for (int i = 0; i < LED_COUNT; i++) begin
					if (32'(ch_s1) == i) begin
						cmp_d[i]  = (sum[i] > SUM_W'(PHASE_TOP)) ? PHASE_TOP
						            : sum[i][PHASE_W-1:0];
						lock_d[i] = 1'b0;
					end
				end
			end
			REQ_LOCK: begin
				for (int i = 0; i < LED_COUNT; i++) begin
					if (32'(ch_s1) == i) begin
						lock_d[i] = 1'b1;
					end
				end
			end
			REQ_STOP: begin
				level_d   = lock_q;
				running_d = 1'b0;
			end
			REQ_START: begin
				running_d = 1'b1;
			end
			default: begin
				// unused codes: state unchanged, result still reported
			end
		endcase

		pattern_d = '0;
		for (int i = 0; i < PAT_N; i++) begin
			pattern_d[i] = level_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			fade_cnt_q <= '0;
			lock_q     <= '0;
			level_q    <= '0;
			running_q  <= 1'b0;
			for (int i = 0; i < LED_COUNT; i++) begin
				cmp_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q    <= phase_d;
			fade_cnt_q <= fade_cnt_d;
			lock_q     <= lock_d;
			level_q    <= level_d;
			running_q  <= running_d;
			for (int i = 0; i < LED_COUNT; i++) begin
				cmp_q[i] <= cmp_d[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {(OUT_DATA_W-PAT_W-1)'(0), running_d, pattern_d};
		end
	end

`ifndef SYNTHESIS
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1 == REQ_STOP |=> !running_q && m_tdata[PAT_W] == 1'b0)
		else $error("stop did not halt the PWM");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1 == REQ_TICK && !running_q |=> $stable(phase_q) && $stable(level_q))
		else $error("tick changed state while stopped");

	a_status_bit: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tdata[PAT_W] == running_q)
		else $error("result status differs from run state");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result lost while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request side stalled with empty result register");
`endif

endmodule
